// ===== rtl/hpbp_pkg.sv =====
package hpbp_pkg;

  localparam int HISTORY_LEN_DEF     = 143;
  localparam int WEIGHT_BITS_DEF     = 8;
  localparam int NUM_TABLES_DEF      = 128;
  localparam int CHOOSER_ENTRIES_DEF = 4096;

  // widest possible dot product: (256 + 1) * 2^11 fits in 24 signed bits
  localparam int ACC_W    = 24;
  localparam int SUM_W    = 16;
  localparam int THR_W    = 10;
  localparam int ADDR_W   = 64;
  localparam int THR_RST  = 289;

  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] branch_address;
    logic              tage_guess;
    logic              taken;
  } item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } q_ctrl_t;

endpackage

// ===== rtl/hpbp_front.sv =====
module hpbp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hpbp_pkg::item_t     in_item,
  output logic                head_valid,
  output hpbp_pkg::item_t     head_item,
  input  hpbp_pkg::q_ctrl_t   ctrl
);

  hpbp_pkg::item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // hold off new items while the queue is full or the back end sweeps its tables
  assign in_ready   = (count != 2'd2) && !ctrl.clearing;
  assign push       = in_valid && in_ready;
  assign pop        = ctrl.pop && (count != 2'd0);
  assign head_valid = (count != 2'd0);
  assign head_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/hpbp_back.sv =====
module hpbp_back #(
  parameter int HISTORY_LEN     = hpbp_pkg::HISTORY_LEN_DEF,
  parameter int WEIGHT_BITS     = hpbp_pkg::WEIGHT_BITS_DEF,
  parameter int NUM_TABLES      = hpbp_pkg::NUM_TABLES_DEF,
  parameter int CHOOSER_ENTRIES = hpbp_pkg::CHOOSER_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [hpbp_pkg::THR_W-1:0]        threshold,
  input  logic                              head_valid,
  input  hpbp_pkg::item_t                   head_item,
  output hpbp_pkg::q_ctrl_t                 ctrl,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              predicted_taken,
  output logic                              used_perceptron,
  output logic signed [hpbp_pkg::SUM_W-1:0] perceptron_sum,
  output logic                              entry_found,
  output logic                              weights_trained
);

  localparam int CI_W   = $clog2(CHOOSER_ENTRIES);
  localparam int PI_W   = $clog2(NUM_TABLES);
  localparam int HI_W   = $clog2(HISTORY_LEN);
  localparam int WD     = NUM_TABLES * HISTORY_LEN;
  localparam int WA_W   = $clog2(WD);
  localparam int CLR_D  = (WD > CHOOSER_ENTRIES) ? WD : CHOOSER_ENTRIES;
  localparam int CL_W   = $clog2(CLR_D);
  localparam int ACC_W  = hpbp_pkg::ACC_W;
  localparam int SUM_W  = hpbp_pkg::SUM_W;
  localparam int WB     = WEIGHT_BITS;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_PWALK = 3'd4;
  localparam logic [2:0] S_PFIN  = 3'd5;
  localparam logic [2:0] S_RWALK = 3'd6;
  localparam logic [2:0] S_RFIN  = 3'd7;

  function automatic logic signed [WB-1:0] sat_step(input logic signed [WB-1:0] w,
                                                    input logic up);
    logic signed [WB-1:0] r;
    begin
      r = w;
      if (up) begin
        if (w != {1'b0, {(WB-1){1'b1}}}) r = w + WB'(1);
      end else begin
        if (w != {1'b1, {(WB-1){1'b0}}}) r = w - WB'(1);
      end
      return r;
    end
  endfunction

  // tables
  logic        [1:0]    chooser_mem [CHOOSER_ENTRIES];
  logic signed [WB-1:0] bias_mem    [NUM_TABLES];
  logic signed [WB-1:0] weight_mem  [WD];

  logic [2:0]  state;
  logic [CL_W-1:0] clr_idx;
  hpbp_pkg::item_t cur;
  logic [CI_W-1:0] ci_rem;
  logic [PI_W-1:0] pi_rem;
  logic [WA_W-1:0] base;
  logic [HI_W-1:0] k;
  logic signed [ACC_W-1:0] acc;
  logic [HISTORY_LEN-1:0] spec_hist;
  logic [HISTORY_LEN-1:0] real_hist;
  logic [HISTORY_LEN-1:0] hold_hist;
  logic        last_tage;
  logic        last_perc;
  logic signed [SUM_W-1:0] last_sum;
  logic        train;

  // memory ports
  logic        [1:0]    ch_rd;
  logic signed [WB-1:0] bias_rd;
  logic signed [WB-1:0] w_rd;
  logic                 ch_we,  bias_we,  w_we;
  logic [CI_W-1:0]      ch_wa;
  logic [PI_W-1:0]      bias_wa;
  logic [WA_W-1:0]      w_wa, w_ra;
  logic        [1:0]    ch_wd;
  logic signed [WB-1:0] bias_wd, w_wd;
  logic                 w_re;

  logic [WA_W-1:0] base_c;
  assign base_c = WA_W'(pi_rem) * WA_W'(HISTORY_LEN);

  // dot product terms and final sum
  logic signed [ACC_W-1:0] w_ext, b_ext, s_full;
  logic signed [SUM_W-1:0] s_sat;
  assign w_ext  = ACC_W'(w_rd);
  assign b_ext  = ACC_W'(bias_rd);
  assign s_full = acc + b_ext;
  always_comb begin
    if (s_full > ACC_W'(32767))       s_sat = 16'sh7fff;
    else if (s_full < -ACC_W'(32768)) s_sat = 16'sh8000;
    else                              s_sat = s_full[SUM_W-1:0];
  end

  // resolve decisions
  logic signed [SUM_W:0] sum_x, thr_x;
  logic mis, train_c, ch_up;
  logic [1:0] ch_new;
  logic [HISTORY_LEN-1:0] real_nx;
  assign sum_x   = (SUM_W+1)'(last_sum);
  assign thr_x   = (SUM_W+1)'(signed'({1'b0, threshold}));
  assign mis     = last_perc != cur.taken;
  assign train_c = ((sum_x <= thr_x) && (sum_x >= -thr_x)) || mis;
  assign real_nx = {real_hist[HISTORY_LEN-2:0], cur.taken};
  assign ch_up   = ch_rd[1] ? (last_perc == cur.taken) : (last_tage != cur.taken);
  always_comb begin
    ch_new = ch_rd;
    if (ch_up) begin
      if (ch_rd != 2'd3) ch_new = ch_rd + 2'd1;
    end else begin
      if (ch_rd != 2'd0) ch_new = ch_rd - 2'd1;
    end
  end

  logic last_k;
  assign last_k = (k == HI_W'(HISTORY_LEN - 1));

  // write/read port selection
  always_comb begin
    ch_we   = 1'b0;
    bias_we = 1'b0;
    w_we    = 1'b0;
    ch_wa   = ci_rem;
    bias_wa = pi_rem;
    w_wa    = base + WA_W'(k);
    ch_wd   = ch_new;
    bias_wd = sat_step(bias_rd, cur.taken);
    w_wd    = sat_step(w_rd, hold_hist[k] == cur.taken);
    w_re    = 1'b0;
    w_ra    = base + WA_W'(k) + WA_W'(1);
    priority case (state)
      S_CLR: begin
        ch_wa   = CI_W'(clr_idx);
        bias_wa = PI_W'(clr_idx);
        w_wa    = WA_W'(clr_idx);
        ch_wd   = 2'd0;
        bias_wd = '0;
        w_wd    = '0;
        ch_we   = 32'(clr_idx) < CHOOSER_ENTRIES;
        bias_we = 32'(clr_idx) < NUM_TABLES;
        w_we    = 32'(clr_idx) < WD;
      end
      S_LOAD: begin
        w_re = 1'b1;
        w_ra = base_c;
      end
      S_PWALK: w_re = !last_k;
      S_RWALK: begin
        w_we = 1'b1;
        w_re = !last_k;
      end
      S_RFIN: begin
        ch_we   = 1'b1;
        bias_we = train;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ch_we) chooser_mem[ch_wa] <= ch_wd;
    if (state == S_LOAD) ch_rd <= chooser_mem[ci_rem];
  end

  always_ff @(posedge clk) begin
    if (bias_we) bias_mem[bias_wa] <= bias_wd;
    if (state == S_LOAD) bias_rd <= bias_mem[pi_rem];
  end

  always_ff @(posedge clk) begin
    if (w_we) weight_mem[w_wa] <= w_wd;
    if (w_re) w_rd <= weight_mem[w_ra];
  end

  assign ctrl.clearing = (state == S_CLR);
  assign ctrl.pop      = (state == S_IDLE) && head_valid && !out_valid;

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      cur <= head_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      ci_rem    <= '0;
      pi_rem    <= '0;
      base      <= '0;
      k         <= '0;
      acc       <= '0;
      train     <= 1'b0;
      spec_hist <= '0;
      real_hist <= '0;
      hold_hist <= '0;
      last_tage <= 1'b0;
      last_perc <= 1'b0;
      last_sum  <= '0;
      out_valid <= 1'b0;
      predicted_taken <= 1'b0;
      used_perceptron <= 1'b0;
      perceptron_sum  <= '0;
      entry_found     <= 1'b0;
      weights_trained <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CL_W'(1);
          if (32'(clr_idx) == CLR_D - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (ctrl.pop) state <= S_MOD;
        end
        S_MOD: begin
          // table sizes are powers of two: the index is the low address bits
          ci_rem <= cur.branch_address[CI_W-1:0];
          pi_rem <= cur.branch_address[PI_W-1:0];
          state  <= S_LOAD;
        end
        S_LOAD: begin
          base <= base_c;
          k    <= '0;
          acc  <= '0;
          if (cur.func == hpbp_pkg::FUNC_PREDICT) begin
            state <= S_PWALK;
          end else begin
            hold_hist <= spec_hist;
            real_hist <= real_nx;
            spec_hist <= mis ? real_nx : {spec_hist[HISTORY_LEN-2:0], last_perc};
            train     <= train_c;
            state     <= train_c ? S_RWALK : S_RFIN;
          end
        end
        S_PWALK: begin
          acc <= spec_hist[k] ? (acc + w_ext) : (acc - w_ext);
          k   <= k + HI_W'(1);
          if (last_k) state <= S_PFIN;
        end
        S_PFIN: begin
          last_sum  <= s_sat;
          last_tage <= cur.tage_guess;
          last_perc <= !s_sat[SUM_W-1];
          out_valid <= 1'b1;
          predicted_taken <= ch_rd[1] ? !s_sat[SUM_W-1] : cur.tage_guess;
          used_perceptron <= ch_rd[1];
          perceptron_sum  <= s_sat;
          entry_found     <= 1'b0;
          weights_trained <= 1'b0;
          state <= S_IDLE;
        end
        S_RWALK: begin
          k <= k + HI_W'(1);
          if (last_k) state <= S_RFIN;
        end
        S_RFIN: begin
          out_valid <= 1'b1;
          predicted_taken <= 1'b0;
          used_perceptron <= 1'b0;
          perceptron_sum  <= last_sum;
          entry_found     <= 1'b1;
          weights_trained <= train;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hybrid_perceptron_branch_predictor_core.sv =====
// Sequence: an accepted item waits in the queue, is popped in idle, has its table indexes
//   formed and its entries loaded; a predict or a training resolve then walks the weights.
// Occupancy: one item in the engine at a time; the serial weight walk must finish and the
//   result must drain before the next item is popped, so a new item is not taken while the
//   last one is in flight. Input transfers queue two deep ahead of the engine.
// Reset (rst, synchronous): clears histories and guesses, loads theta with 289, then sweeps the
//   weight, bias and chooser tables to zero up to max(NUM_TABLES * HISTORY_LEN, CHOOSER_ENTRIES).
module hybrid_perceptron_branch_predictor_core #(
  parameter int HISTORY_LEN     = hpbp_pkg::HISTORY_LEN_DEF,
  parameter int WEIGHT_BITS     = hpbp_pkg::WEIGHT_BITS_DEF,
  parameter int NUM_TABLES      = hpbp_pkg::NUM_TABLES_DEF,
  parameter int CHOOSER_ENTRIES = hpbp_pkg::CHOOSER_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [hpbp_pkg::THR_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [hpbp_pkg::ADDR_W-1:0]       branch_address,
  input  logic                              tage_guess,
  input  logic                              taken,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              predicted_taken,
  output logic                              used_perceptron,
  output logic signed [hpbp_pkg::SUM_W-1:0] perceptron_sum,
  output logic                              entry_found,
  output logic                              weights_trained
);

  // Training threshold (theta), written from the config port
  logic [hpbp_pkg::THR_W-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= hpbp_pkg::THR_W'(hpbp_pkg::THR_RST);
    end else if (cfg_wen) begin
      threshold <= cfg_wdata;
    end
  end

  hpbp_pkg::item_t   in_item;
  hpbp_pkg::item_t   head_item;
  hpbp_pkg::q_ctrl_t ctrl;
  logic              head_valid;

  assign in_item.func           = func;
  assign in_item.branch_address = branch_address;
  assign in_item.tage_guess     = tage_guess;
  assign in_item.taken          = taken;

  // Front: hold accepted items in a short queue so the engine can stall alone
  hpbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .ctrl       (ctrl)
  );

  // Back: address indexing, dot product walk, training walk and result register
  hpbp_back #(
    .HISTORY_LEN     (HISTORY_LEN),
    .WEIGHT_BITS     (WEIGHT_BITS),
    .NUM_TABLES      (NUM_TABLES),
    .CHOOSER_ENTRIES (CHOOSER_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .threshold       (threshold),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .ctrl            (ctrl),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .predicted_taken (predicted_taken),
    .used_perceptron (used_perceptron),
    .perceptron_sum  (perceptron_sum),
    .entry_found     (entry_found),
    .weights_trained (weights_trained)
  );

  // No input transfer while the tables are swept
  a_no_in_during_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.clearing |-> !in_ready)
    else $error("input transfer during table sweep");

  // A resolve result never carries a prediction
  a_resolve_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_found) |-> (!predicted_taken && !used_perceptron))
    else $error("resolve result carries prediction bits");

  // Training only happens on a matched resolve
  a_train_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && weights_trained) |-> entry_found)
    else $error("weights trained without a match");

  // Engine never pops while a result waits
  a_pop_blocked: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> !out_valid)
    else $error("queue pop while result pending");

endmodule
